/* rtl/lcdseq_pkg.sv */
package lcdseq_pkg;

  localparam logic [2:0] KIND_CMD    = 3'd0;
  localparam logic [2:0] KIND_CHAR   = 3'd1;
  localparam logic [2:0] KIND_CURSOR = 3'd2;
  localparam logic [2:0] KIND_NUMBER = 3'd3;
  localparam logic [2:0] KIND_INIT   = 3'd4;

  localparam logic REG_DEVICE_ADDRESS = 1'b0;
  localparam logic REG_BACKLIGHT_ON   = 1'b1;

  localparam logic [2:0] STEP_ADDR   = 3'd0;
  localparam logic [2:0] STEP_HI_ON  = 3'd1;
  localparam logic [2:0] STEP_HI_OFF = 3'd2;
  localparam logic [2:0] STEP_LO_ON  = 3'd3;
  localparam logic [2:0] STEP_LO_OFF = 3'd4;

  localparam logic [7:0] BL_BIT     = 8'h08;
  localparam logic [7:0] EN_BIT     = 8'h04;
  localparam logic [7:0] RS_BIT     = 8'h01;
  localparam logic [7:0] ROW1_BASE  = 8'h40;
  localparam logic [7:0] CURSOR_CMD = 8'h80;
  localparam logic [7:0] ASCII_ZERO = 8'h30;

  localparam logic [2:0] INIT_LAST  = 3'd5;
  localparam logic [2:0] DIGIT_LAST = 3'd4;

  typedef struct packed {
    logic [7:0] data;
    logic       rs;
    logic       last;
  } lcd_entry_t;

  typedef struct packed {
    logic [6:0] dev_addr;
    logic       backlight;
  } cfg_t;

  function automatic logic [7:0] init_cmd(input logic [2:0] idx);
    logic [7:0] cmd;
    case (idx)
      3'd0:    cmd = 8'h33;
      3'd1:    cmd = 8'h32;
      3'd2:    cmd = 8'h28;
      3'd3:    cmd = 8'h0C;
      3'd4:    cmd = 8'h06;
      default: cmd = 8'h01;
    endcase
    return cmd;
  endfunction

endpackage

/* rtl/lcdseq_if.sv */
interface lcdseq_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  byte_value;
  logic        row;
  logic [5:0]  column;
  logic [15:0] number;

  modport source (output valid, kind, byte_value, row, column, number, input ready);
  modport sink (input valid, kind, byte_value, row, column, number, output ready);
endinterface

interface lcdseq_bus_if;
  logic       valid;
  logic       ready;
  logic [7:0] bus_byte;
  logic       start_before;
  logic       stop_after;
  logic       last;

  modport source (output valid, bus_byte, start_before, stop_after, last, input ready);
  modport sink (input valid, bus_byte, start_before, stop_after, last, output ready);
endinterface

/* rtl/lcdseq_front.sv */
module lcdseq_front (
  input  logic                   clk,
  input  logic                   rst,
  lcdseq_req_if.sink             req,
  output lcdseq_pkg::lcd_entry_t entry,
  output logic                   entry_valid,
  input  logic                   entry_ready
);
  import lcdseq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_ONE    = 5'b00010,
    S_INIT   = 5'b00100,
    S_CONV   = 5'b01000,
    S_DIGITS = 5'b10000
  } state_t;

  state_t      state;
  state_t      state_next;
  logic [3:0]  cnt;
  logic [7:0]  one_data;
  logic        one_rs;
  logic [15:0] bin;
  logic [19:0] bcd;
  logic [19:0] bcd_adj;
  logic [19:0] bcd_shift;
  logic [3:0]  digits [5];
  logic [2:0]  start_idx;
  logic [7:0]  row_base;
  logic        accept;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign row_base  = req.row ? ROW1_BASE : 8'h00;

  // One step of shift-and-add-3 binary to BCD conversion.
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
    bcd_shift = {bcd_adj[18:0], bin[15]};
  end

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      digits[i] = bcd[(4 - i)*4 +: 4];
    end
  end

  // The first printed digit is the leading nonzero one, or the units digit.
  always_comb begin
    start_idx = DIGIT_LAST;
    for (int i = 3; i >= 0; i--) begin
      if (bcd_shift[(4 - i)*4 +: 4] != 4'd0) begin
        start_idx = 3'(i);
      end
    end
  end

  always_comb begin
    entry_valid = 1'b0;
    entry       = '0;
    unique case (state)
      S_ONE: begin
        entry_valid = 1'b1;
        entry.data  = one_data;
        entry.rs    = one_rs;
        entry.last  = 1'b1;
      end
      S_INIT: begin
        entry_valid = 1'b1;
        entry.data  = init_cmd(cnt[2:0]);
        entry.last  = (cnt[2:0] == INIT_LAST);
      end
      S_DIGITS: begin
        entry_valid = 1'b1;
        entry.data  = ASCII_ZERO | {4'b0000, digits[cnt[2:0]]};
        entry.rs    = 1'b1;
        entry.last  = (cnt[2:0] == DIGIT_LAST);
      end
      default: begin
        entry_valid = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (req.kind) inside
            KIND_CMD, KIND_CHAR, KIND_CURSOR: state_next = S_ONE;
            KIND_NUMBER:                      state_next = S_CONV;
            KIND_INIT:                        state_next = S_INIT;
            default:                          state_next = S_IDLE;
          endcase
        end
      end
      S_ONE: begin
        if (entry_ready) state_next = S_IDLE;
      end
      S_INIT: begin
        if (entry_ready && cnt[2:0] == INIT_LAST) state_next = S_IDLE;
      end
      S_CONV: begin
        if (cnt == 4'd15) state_next = S_DIGITS;
      end
      S_DIGITS: begin
        if (entry_ready && cnt[2:0] == DIGIT_LAST) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cnt      <= 4'd0;
      one_data <= (req.kind == KIND_CURSOR) ?
                  (CURSOR_CMD | (row_base + {2'b00, req.column})) : req.byte_value;
      one_rs   <= (req.kind == KIND_CHAR);
      bin      <= req.number;
      bcd      <= '0;
    end else if (state == S_CONV) begin
      bin <= {bin[14:0], 1'b0};
      bcd <= bcd_shift;
      if (cnt == 4'd15) begin
        cnt <= {1'b0, start_idx};
      end else begin
        cnt <= cnt + 4'd1;
      end
    end else if ((state == S_INIT || state == S_DIGITS) && entry_ready) begin
      cnt <= cnt + 4'd1;
    end
  end

endmodule

/* rtl/lcdseq_fifo.sv */
module lcdseq_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  lcdseq_pkg::lcd_entry_t in_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  output lcdseq_pkg::lcd_entry_t out_data,
  output logic                   out_valid,
  input  logic                   out_ready
);
  import lcdseq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR   = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  lcd_entry_t    mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign in_ready  = (count != FULL_COUNT);
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL_COUNT)
    else $error("Queue fill count exceeds its depth.");

endmodule

/* rtl/lcdseq_back.sv */
module lcdseq_back (
  input  logic                   clk,
  input  logic                   rst,
  input  lcdseq_pkg::cfg_t       cfg,
  input  lcdseq_pkg::lcd_entry_t entry,
  input  logic                   entry_valid,
  output logic                   entry_ready,
  lcdseq_bus_if.source           bus
);
  import lcdseq_pkg::*;

  lcd_entry_t cur;
  logic       have;
  logic [2:0] step;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_start;
  logic       out_stop;
  logic       out_last;
  logic       advance;
  logic       pop;
  logic [7:0] flags;
  logic [7:0] hi;
  logic [7:0] lo;
  logic [7:0] byte_next;

  assign advance     = have && (!out_valid || bus.ready);
  assign entry_ready = !have || (advance && step == STEP_LO_OFF);
  assign pop         = entry_ready && entry_valid;

  assign flags = (cfg.backlight ? BL_BIT : 8'h00) | (cur.rs ? RS_BIT : 8'h00);
  assign hi    = {cur.data[7:4], 4'b0000} | flags;
  assign lo    = {cur.data[3:0], 4'b0000} | flags;

  always_comb begin
    unique case (step)
      STEP_ADDR:   byte_next = {cfg.dev_addr, 1'b0};
      STEP_HI_ON:  byte_next = hi | EN_BIT;
      STEP_HI_OFF: byte_next = hi;
      STEP_LO_ON:  byte_next = lo | EN_BIT;
      default:     byte_next = lo;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have      <= 1'b0;
      step      <= STEP_ADDR;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (bus.ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        have <= 1'b1;
        step <= STEP_ADDR;
      end else if (advance) begin
        if (step == STEP_LO_OFF) begin
          have <= 1'b0;
        end else begin
          step <= step + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= entry;
    end
    if (advance) begin
      out_byte  <= byte_next;
      out_start <= (step == STEP_ADDR);
      out_stop  <= (step == STEP_LO_OFF);
      out_last  <= (step == STEP_LO_OFF) && cur.last;
    end
  end

  assign bus.valid        = out_valid;
  assign bus.bus_byte     = out_byte;
  assign bus.start_before = out_start;
  assign bus.stop_after   = out_stop;
  assign bus.last         = out_last;

  a_last_has_stop: assert property (@(posedge clk) disable iff (rst)
    bus.valid && bus.last |-> bus.stop_after)
    else $error("Final word of a request lacks a stop marker.");

  a_addr_is_write: assert property (@(posedge clk) disable iff (rst)
    bus.valid && bus.start_before |-> !bus.stop_after && bus.bus_byte[0] == 1'b0)
    else $error("Address word is not a plain write address.");

  a_step_range: assert property (@(posedge clk) disable iff (rst) have |-> step <= STEP_LO_OFF)
    else $error("Byte step counter out of range.");

endmodule

/* rtl/i2c_char_lcd_command_sequencer.sv */
// Channel  Direction  Fields
// req      in         kind, byte_value, row, column, number
// bus      out        bus_byte, start_before, stop_after, last
// cfg      in         cfg_we, cfg_index, cfg_data (write only)
//
// Every LCD byte becomes five bus words in the back end.
// A number request runs a binary to BCD conversion before its first digit is queued.
// Reset clears the control state and loads address 39 with the backlight on.
// A stalled bus holds the back end, and the front end stops once the queue fills.
module i2c_char_lcd_command_sequencer #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  lcdseq_req_if.sink   req,
  lcdseq_bus_if.source bus,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [6:0]   cfg_data
);
  import lcdseq_pkg::*;

  cfg_t       cfg;
  lcd_entry_t front_entry;
  logic       front_valid;
  logic       front_ready;
  lcd_entry_t back_entry;
  logic       back_valid;
  logic       back_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dev_addr  <= 7'd39;
      cfg.backlight <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEVICE_ADDRESS: cfg.dev_addr  <= cfg_data;
        REG_BACKLIGHT_ON:   cfg.backlight <= cfg_data[0];
        default:            cfg.backlight <= cfg.backlight;
      endcase
    end
  end

  lcdseq_front u_front (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .entry       (front_entry),
    .entry_valid (front_valid),
    .entry_ready (front_ready)
  );

  lcdseq_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_data   (front_entry),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .out_data  (back_entry),
    .out_valid (back_valid),
    .out_ready (back_ready)
  );

  lcdseq_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .entry       (back_entry),
    .entry_valid (back_valid),
    .entry_ready (back_ready),
    .bus         (bus)
  );

endmodule
